[src/rlkns_pkg.sv]
package rlkns_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned ID_W = 9;
  localparam int unsigned DIST_W = 33;
  localparam int unsigned SQ_W = 2 * COORD_W;

  localparam int unsigned NEIGHBOR_SLOTS_DEFAULT = 3;
  localparam int unsigned POINT_COUNT_DEFAULT = 512;

  localparam logic [DIST_W-1:0] RADIUS_SQ_RESET = 33'd64000000;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_CANDIDATE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [ID_W-1:0]    point_id;
    logic              final_candidate;
  } in_item_t;

  typedef struct packed {
    logic              slot_valid;
    logic [ID_W-1:0]   neighbor_id;
    logic [DIST_W-1:0] neighbor_dist_sq;
    logic              end_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_SCAN,
    ST_UPDATE,
    ST_LOAD,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load_query;
    logic load_cand;
    logic square_en;
    logic sum_en;
    logic scan_en;
    logic update_en;
    logic ptr_clr;
    logic emit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cand_final;
    logic ptr_last;
    logic out_last;
  } dp_status_t;

endpackage

[src/radius_limited_k_nearest_select.sv]
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o    in_data_i   (rlkns_pkg::in_item_t)
// out       output     out_valid_o/out_ready_i  out_data_o  (rlkns_pkg::out_item_t)
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_data_i  (radius squared, 33 bits)
//
// A start request loads the query. A candidate passes the square, sum, scan and update
// states, the scan visiting one slot per cycle; a final candidate then adds a load state
// and NEIGHBOR_SLOTS results, one slot per cycle while out_ready_i stays high.
// Reset is asynchronous, active low, and leaves all slots empty and the query at the origin.
// The block takes one request at a time and holds each result until out_ready_i takes it.
module radius_limited_k_nearest_select #(
  parameter int unsigned NEIGHBOR_SLOTS = rlkns_pkg::NEIGHBOR_SLOTS_DEFAULT,
  parameter int unsigned POINT_COUNT = rlkns_pkg::POINT_COUNT_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rlkns_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rlkns_pkg::out_item_t          out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlkns_pkg::DIST_W-1:0]  cfg_data_i
);

  rlkns_pkg::ctrl_cmd_t  cmd;
  rlkns_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rlkns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rlkns_datapath #(
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS),
    .POINT_COUNT    (POINT_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

[src/rlkns_ctrl.sv]
module rlkns_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rlkns_pkg::dp_status_t status_i,
  output rlkns_pkg::ctrl_cmd_t  cmd_o
);

  rlkns_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlkns_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      rlkns_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == rlkns_pkg::KIND_START) begin
            cmd_o.load_query = 1'b1;
          end else begin
            cmd_o.load_cand = 1'b1;
            cmd_o.ptr_clr = 1'b1;
            state_d = rlkns_pkg::ST_SQUARE;
          end
        end
      end
      rlkns_pkg::ST_SQUARE: begin
        cmd_o.square_en = 1'b1;
        state_d = rlkns_pkg::ST_SUM;
      end
      rlkns_pkg::ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d = rlkns_pkg::ST_SCAN;
      end
      rlkns_pkg::ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.ptr_last) begin
          state_d = rlkns_pkg::ST_UPDATE;
        end
      end
      rlkns_pkg::ST_UPDATE: begin
        cmd_o.update_en = 1'b1;
        cmd_o.ptr_clr = 1'b1;
        state_d = status_i.cand_final ? rlkns_pkg::ST_LOAD : rlkns_pkg::ST_IDLE;
      end
      rlkns_pkg::ST_LOAD: begin
        // The slots were written on the previous edge, so they are read here.
        cmd_o.emit_load = 1'b1;
        state_d = rlkns_pkg::ST_EMIT;
      end
      rlkns_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = rlkns_pkg::ST_IDLE;
          end else begin
            cmd_o.emit_load = 1'b1;
          end
        end
      end
      default: begin
        state_d = rlkns_pkg::ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_last_result_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && status_i.out_last) |=> (state_q == rlkns_pkg::ST_IDLE))
    else $error("emission did not end after the last slot");

  a_candidate_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_kind_i == rlkns_pkg::KIND_CANDIDATE))
    |=> (state_q == rlkns_pkg::ST_SQUARE))
    else $error("accepted candidate did not start the distance pipeline");

endmodule

[src/rlkns_datapath.sv]
module rlkns_datapath #(
  parameter int unsigned NEIGHBOR_SLOTS = rlkns_pkg::NEIGHBOR_SLOTS_DEFAULT,
  parameter int unsigned POINT_COUNT = rlkns_pkg::POINT_COUNT_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rlkns_pkg::in_item_t           in_data_i,
  input  logic                          cfg_we_i,
  input  logic [rlkns_pkg::DIST_W-1:0]  cfg_data_i,
  input  rlkns_pkg::ctrl_cmd_t          cmd_i,
  output rlkns_pkg::dp_status_t         status_o,
  output rlkns_pkg::out_item_t          out_data_o
);

  localparam int unsigned SlotW = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
  localparam int unsigned CW = rlkns_pkg::COORD_W;
  localparam int unsigned IW = rlkns_pkg::ID_W;
  localparam int unsigned DW = rlkns_pkg::DIST_W;
  localparam int unsigned SW = rlkns_pkg::SQ_W;

  logic [DW-1:0] radius_q;
  logic [CW-1:0] query_x_q, query_y_q;
  logic [IW-1:0] query_id_q;

  logic [CW-1:0] cand_x_q, cand_y_q;
  logic [IW-1:0] cand_id_q;
  logic          cand_fin_q;

  logic [SW-1:0] dx2_q, dy2_q;
  logic [DW-1:0] dist_q;
  logic          cand_ok_q;

  logic [NEIGHBOR_SLOTS-1:0] filled_q;
  logic [IW-1:0]             slot_id_q   [NEIGHBOR_SLOTS];
  logic [DW-1:0]             slot_dist_q [NEIGHBOR_SLOTS];

  logic [SlotW-1:0] ptr_q, ptr_d;
  logic [SlotW-1:0] worst_q;
  logic [DW-1:0]    worst_dist_q;
  logic             worst_empty_q;

  rlkns_pkg::out_item_t out_q;

  logic [CW-1:0] dx, dy;
  logic [DW-1:0] dist_sum;
  logic          id_ok;
  logic          ptr_last;
  logic          rd_filled;
  logic [IW-1:0] rd_id;
  logic [DW-1:0] rd_dist;
  logic          do_write;

  assign dx = (cand_x_q > query_x_q) ? cand_x_q - query_x_q : query_x_q - cand_x_q;
  assign dy = (cand_y_q > query_y_q) ? cand_y_q - query_y_q : query_y_q - cand_y_q;
  assign dist_sum = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign id_ok = ({{(32 - IW){1'b0}}, cand_id_q} < 32'(POINT_COUNT)) &&
                 (cand_id_q != query_id_q);

  assign ptr_last = (ptr_q == SlotW'(NEIGHBOR_SLOTS - 1));
  assign rd_filled = filled_q[ptr_q];
  assign rd_id = slot_id_q[ptr_q];
  assign rd_dist = slot_dist_q[ptr_q];

  // An empty slot always loses to an accepted candidate; a filled one only to a strictly nearer one.
  assign do_write = cmd_i.update_en && cand_ok_q && (worst_empty_q || (dist_q < worst_dist_q));

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if ((cmd_i.scan_en || cmd_i.emit_load) && !ptr_last) begin
      ptr_d = ptr_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rlkns_pkg::RADIUS_SQ_RESET;
      query_x_q <= '0;
      query_y_q <= '0;
      query_id_q <= '0;
      filled_q <= '0;
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cfg_we_i) begin
        radius_q <= cfg_data_i;
      end
      if (cmd_i.load_query) begin
        query_x_q <= in_data_i.pos_x;
        query_y_q <= in_data_i.pos_y;
        query_id_q <= in_data_i.point_id;
        filled_q <= '0;
      end else if (do_write) begin
        filled_q[worst_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cand) begin
      cand_x_q <= in_data_i.pos_x;
      cand_y_q <= in_data_i.pos_y;
      cand_id_q <= in_data_i.point_id;
      cand_fin_q <= in_data_i.final_candidate;
    end
    if (cmd_i.square_en) begin
      dx2_q <= SW'(dx) * SW'(dx);
      dy2_q <= SW'(dy) * SW'(dy);
    end
    if (cmd_i.sum_en) begin
      dist_q <= dist_sum;
      cand_ok_q <= id_ok && (dist_sum <= radius_q);
    end
    if (cmd_i.scan_en) begin
      if (ptr_q == '0) begin
        worst_q <= '0;
        worst_dist_q <= rd_dist;
        worst_empty_q <= !rd_filled;
      end else if (!worst_empty_q) begin
        if (!rd_filled) begin
          worst_q <= ptr_q;
          worst_empty_q <= 1'b1;
        end else if (rd_dist > worst_dist_q) begin
          worst_q <= ptr_q;
          worst_dist_q <= rd_dist;
        end
      end
    end
    if (do_write) begin
      slot_id_q[worst_q] <= cand_id_q;
      slot_dist_q[worst_q] <= dist_q;
    end
    if (cmd_i.emit_load) begin
      out_q.slot_valid <= rd_filled;
      out_q.neighbor_id <= rd_filled ? rd_id : '0;
      out_q.neighbor_dist_sq <= rd_filled ? rd_dist : '0;
      out_q.end_of_run <= ptr_last;
    end
  end

  assign out_data_o = out_q;
  assign status_o.cand_final = cand_fin_q;
  assign status_o.ptr_last = ptr_last;
  assign status_o.out_last = out_q.end_of_run;

  a_worst_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update_en |-> (32'(worst_q) < NEIGHBOR_SLOTS))
    else $error("replacement slot out of range");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_query |=> (filled_q == '0))
    else $error("start did not empty the slots");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load_query |=> ($countones(filled_q) >= $past($countones(filled_q))))
    else $error("a slot emptied without a start");

endmodule
